/* rtl/core/mesh_layer_extrusion_connectivity_defines.svh */
// Assertion helpers for the extrusion block. Every use samples clk and is
// disabled while rst is high.
`ifndef MESH_LAYER_EXTRUSION_CONNECTIVITY_DEFINES_SVH
`define MESH_LAYER_EXTRUSION_CONNECTIVITY_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MLEC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MLEC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mlec_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mlec_pkg;

  localparam int NODE_ID_BITS = 16;
  localparam int LAYER_BITS   = 8;
  localparam int ID_BITS      = 24;
  localparam int MAT_BITS     = 16;
  localparam int BNC_BITS     = 17;
  localparam int PROD_BITS    = LAYER_BITS + BNC_BITS;
  localparam int VERT_COUNT   = 8;
  localparam int IDX_BITS     = 3;

  localparam int S_TDATA_BITS = 88;
  localparam int S_TUSER_BITS = 3;
  localparam int M_TDATA_BITS = 232;
  localparam int M_TUSER_BITS = 3;
  localparam int PADDR_BITS   = 5;
  localparam int PDATA_BITS   = 32;

  // Element dimensions
  localparam logic [1:0] DIM_POINT = 2'd0;
  localparam logic [1:0] DIM_LINE  = 2'd1;
  localparam logic [1:0] DIM_SURF  = 2'd2;
  localparam logic [1:0] DIM_BAD   = 2'd3;

  typedef enum logic [2:0] {
    SHAPE_POINT = 3'd0,
    SHAPE_LINE  = 3'd1,
    SHAPE_TRI   = 3'd2,
    SHAPE_QUAD  = 3'd3,
    SHAPE_PRISM = 3'd4,
    SHAPE_CUBE  = 3'd5,
    SHAPE_TETRA = 3'd6,
    SHAPE_ERROR = 3'd7
  } shape_t;

  typedef enum logic [2:0] {
    REG_MESH_DIM        = 3'd0,
    REG_LAYER_COUNT     = 3'd1,
    REG_BASE_NODE_COUNT = 3'd2,
    REG_USE_QUADS       = 3'd3,
    REG_USE_PRISMS      = 3'd4,
    REG_USE_TETRA       = 3'd5,
    REG_FRONT_MATERIAL  = 3'd6,
    REG_BACK_MATERIAL   = 3'd7
  } reg_index_t;

  localparam logic signed [MAT_BITS-1:0] FRONT_MATERIAL_RST = -16'sd999;
  localparam logic signed [MAT_BITS-1:0] BACK_MATERIAL_RST  = -16'sd1000;

  typedef struct packed {
    logic [1:0]                  mesh_dim;
    logic [LAYER_BITS-1:0]       layer_count;
    logic [BNC_BITS-1:0]         base_node_count;
    logic                        use_quads;
    logic                        use_prisms;
    logic                        use_tetra;
    logic signed [MAT_BITS-1:0]  front_material;
    logic signed [MAT_BITS-1:0]  back_material;
  } cfg_t;

  // One held input element with its layer offsets already worked out
  typedef struct packed {
    logic [1:0]                  dim;
    logic                        is_quad;
    logic signed [MAT_BITS-1:0]  material;
    logic [NODE_ID_BITS-1:0]     a;
    logic [NODE_ID_BITS-1:0]     b;
    logic [NODE_ID_BITS-1:0]     c;
    logic [NODE_ID_BITS-1:0]     d;
    logic [ID_BITS-1:0]          lo;
    logic [ID_BITS-1:0]          hi;
    logic                        err;
    logic                        first;
    logic                        lastl;
  } item_t;

endpackage

`default_nettype wire

/* rtl/core/mlec_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module mlec_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mlec_pkg::PADDR_BITS-1:0]  paddr,
  input  wire logic [mlec_pkg::PDATA_BITS-1:0]  pwdata,
  output logic      [mlec_pkg::PDATA_BITS-1:0]  prdata,
  output logic                                  pready,
  output mlec_pkg::cfg_t                        cfg
);
  import mlec_pkg::*;

  reg_index_t idx;
  logic       wr;

  assign idx    = reg_index_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mesh_dim        <= DIM_SURF;
      cfg.layer_count     <= LAYER_BITS'(1);
      cfg.base_node_count <= BNC_BITS'(1);
      cfg.use_quads       <= 1'b1;
      cfg.use_prisms      <= 1'b0;
      cfg.use_tetra       <= 1'b0;
      cfg.front_material  <= FRONT_MATERIAL_RST;
      cfg.back_material   <= BACK_MATERIAL_RST;
    end else if (wr) begin
      case (idx)
        REG_MESH_DIM:        cfg.mesh_dim        <= pwdata[1:0];
        REG_LAYER_COUNT:     cfg.layer_count     <= pwdata[LAYER_BITS-1:0];
        REG_BASE_NODE_COUNT: cfg.base_node_count <= pwdata[BNC_BITS-1:0];
        REG_USE_QUADS:       cfg.use_quads       <= pwdata[0];
        REG_USE_PRISMS:      cfg.use_prisms      <= pwdata[0];
        REG_USE_TETRA:       cfg.use_tetra       <= pwdata[0];
        REG_FRONT_MATERIAL:  cfg.front_material  <= pwdata[MAT_BITS-1:0];
        REG_BACK_MATERIAL:   cfg.back_material   <= pwdata[MAT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MESH_DIM:        prdata = {30'd0, cfg.mesh_dim};
      REG_LAYER_COUNT:     prdata = {{(PDATA_BITS-LAYER_BITS){1'b0}}, cfg.layer_count};
      REG_BASE_NODE_COUNT: prdata = {{(PDATA_BITS-BNC_BITS){1'b0}}, cfg.base_node_count};
      REG_USE_QUADS:       prdata = {31'd0, cfg.use_quads};
      REG_USE_PRISMS:      prdata = {31'd0, cfg.use_prisms};
      REG_USE_TETRA:       prdata = {31'd0, cfg.use_tetra};
      REG_FRONT_MATERIAL:  prdata = {{(PDATA_BITS-MAT_BITS){1'b0}}, cfg.front_material};
      REG_BACK_MATERIAL:   prdata = {{(PDATA_BITS-MAT_BITS){1'b0}}, cfg.back_material};
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/mlec_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module mlec_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [mlec_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,
  input  wire logic [mlec_pkg::S_TUSER_BITS-1:0]  s_axis_tuser,
  input  wire mlec_pkg::cfg_t                     cfg,
  input  wire logic                               take,
  output logic                                    item_valid,
  output mlec_pkg::item_t                         item
);
  import mlec_pkg::*;

  logic [LAYER_BITS-1:0] layer;
  logic [LAYER_BITS-1:0] layer_m1;
  logic [PROD_BITS-1:0]  prod_lo;
  logic [PROD_BITS-1:0]  prod_hi;
  logic [1:0]            dim;
  logic                  accept;
  item_t                 item_next;

  assign layer    = s_axis_tdata[87:80];
  assign dim      = s_axis_tuser[1:0];
  assign layer_m1 = layer - LAYER_BITS'(1);
  assign prod_lo  = {{BNC_BITS{1'b0}}, layer_m1} * {{LAYER_BITS{1'b0}}, cfg.base_node_count};
  assign prod_hi  = {{BNC_BITS{1'b0}}, layer} * {{LAYER_BITS{1'b0}}, cfg.base_node_count};

  assign s_axis_tready = !item_valid || take;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_next.dim      = dim;
    item_next.is_quad  = s_axis_tuser[2];
    item_next.material = s_axis_tdata[15:0];
    item_next.a        = s_axis_tdata[31:16];
    item_next.b        = s_axis_tdata[47:32];
    item_next.c        = s_axis_tdata[63:48];
    item_next.d        = s_axis_tdata[79:64];
    item_next.lo       = prod_lo[ID_BITS-1:0];
    item_next.hi       = prod_hi[ID_BITS-1:0];
    item_next.err      = (dim == DIM_BAD) || (layer == '0) || (layer > cfg.layer_count);
    item_next.first    = (layer == LAYER_BITS'(1));
    item_next.lastl    = (layer == cfg.layer_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mlec_emit.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "mesh_layer_extrusion_connectivity_defines.svh"

module mlec_emit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire mlec_pkg::cfg_t                     cfg,
  input  wire logic                               item_valid,
  input  wire mlec_pkg::item_t                    item,
  output logic                                    take,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [mlec_pkg::M_TDATA_BITS-1:0]       m_axis_tdata,
  output logic [mlec_pkg::M_TUSER_BITS-1:0]       m_axis_tuser,
  output logic                                    m_axis_tlast
);
  import mlec_pkg::*;

  logic [IDX_BITS-1:0]                  idx;
  logic [IDX_BITS-1:0]                  count;
  logic [IDX_BITS-1:0]                  nmain;
  logic [IDX_BITS-1:0]                  pos;
  logic [ID_BITS-1:0]                   next_id;
  logic                                 bnd;
  logic                                 front;
  logic                                 back;
  logic                                 is_front;
  logic                                 is_back;
  logic                                 is_last;
  logic                                 load;
  logic [ID_BITS-1:0]                   a0, b0, c0, d0, a1, b1, c1, d1;
  logic [ID_BITS-1:0]                   ba, bb, bc, bd;
  shape_t                               shape_next;
  logic signed [MAT_BITS-1:0]           mat_next;
  logic [VERT_COUNT-1:0][ID_BITS-1:0]   vert_next;
  logic [VERT_COUNT-1:0][ID_BITS-1:0]   vert_q;
  logic signed [MAT_BITS-1:0]           mat_q;
  logic [ID_BITS-1:0]                   id_q;
  shape_t                               shape_q;
  logic                                 last_q;

  localparam int PAD = ID_BITS - NODE_ID_BITS;

  assign a0 = {{PAD{1'b0}}, item.a} + item.lo;
  assign b0 = {{PAD{1'b0}}, item.b} + item.lo;
  assign c0 = {{PAD{1'b0}}, item.c} + item.lo;
  assign d0 = {{PAD{1'b0}}, item.d} + item.lo;
  assign a1 = {{PAD{1'b0}}, item.a} + item.hi;
  assign b1 = {{PAD{1'b0}}, item.b} + item.hi;
  assign c1 = {{PAD{1'b0}}, item.c} + item.hi;
  assign d1 = {{PAD{1'b0}}, item.d} + item.hi;

  assign bnd   = (cfg.mesh_dim == item.dim);
  assign front = bnd && item.first;
  assign back  = bnd && item.lastl;

  always_comb begin
    case (item.dim)
      DIM_LINE: nmain = cfg.use_quads ? IDX_BITS'(1) : IDX_BITS'(2);
      DIM_SURF: nmain = (!cfg.use_prisms && cfg.use_tetra) ? IDX_BITS'(3) : IDX_BITS'(1);
      default:  nmain = IDX_BITS'(1);
    endcase
  end

  assign count    = item.err ? IDX_BITS'(1)
                             : nmain + IDX_BITS'(front) + IDX_BITS'(back);
  assign pos      = idx - IDX_BITS'(front) - IDX_BITS'(back);
  assign is_last  = (idx == count - IDX_BITS'(1));
  assign is_front = front && (idx == '0);
  assign is_back  = back && (idx == IDX_BITS'(front));

  // Boundary copies take the lower layer only for the front copy
  assign ba = is_front ? a0 : a1;
  assign bb = is_front ? b0 : b1;
  assign bc = is_front ? c0 : c1;
  assign bd = is_front ? d0 : d1;

  always_comb begin
    shape_next = SHAPE_ERROR;
    mat_next   = item.material;
    vert_next  = '0;
    if (item.err) begin
      shape_next = SHAPE_ERROR;
    end else if (is_front || is_back) begin
      mat_next = is_front ? cfg.front_material : cfg.back_material;
      case (item.dim)
        DIM_POINT: begin
          shape_next   = SHAPE_POINT;
          vert_next[0] = ba;
        end
        DIM_LINE: begin
          shape_next   = SHAPE_LINE;
          vert_next[0] = ba;
          vert_next[1] = bb;
        end
        default: begin
          shape_next   = item.is_quad ? SHAPE_QUAD : SHAPE_TRI;
          vert_next[0] = ba;
          vert_next[1] = bb;
          vert_next[2] = bc;
          vert_next[3] = item.is_quad ? bd : '0;
        end
      endcase
    end else begin
      case (item.dim)
        DIM_POINT: begin
          shape_next   = SHAPE_LINE;
          vert_next[0] = a0;
          vert_next[1] = a1;
        end
        DIM_LINE: begin
          if (cfg.use_quads) begin
            shape_next = SHAPE_QUAD;
            vert_next[0] = a0;
            vert_next[1] = b0;
            vert_next[2] = b1;
            vert_next[3] = a1;
          end else begin
            shape_next = SHAPE_TRI;
            vert_next[0] = (pos == '0) ? a0 : b0;
            vert_next[1] = (pos == '0) ? b0 : b1;
            vert_next[2] = a1;
          end
        end
        default: begin
          if (cfg.use_prisms) begin
            shape_next = SHAPE_PRISM;
            vert_next[0] = a0;
            vert_next[1] = b0;
            vert_next[2] = c0;
            vert_next[3] = a1;
            vert_next[4] = b1;
            vert_next[5] = c1;
          end else if (!cfg.use_tetra) begin
            shape_next = SHAPE_CUBE;
            vert_next  = {d1, c1, b1, a1, d0, c0, b0, a0};
          end else begin
            shape_next = SHAPE_TETRA;
            vert_next[3] = c0;
            case (pos)
              IDX_BITS'(0): begin
                vert_next[0] = a0;
                vert_next[1] = b0;
                vert_next[2] = a1;
              end
              IDX_BITS'(1): begin
                vert_next[0] = b0;
                vert_next[1] = b1;
                vert_next[2] = a1;
              end
              default: begin
                vert_next[0] = a1;
                vert_next[1] = b1;
                vert_next[2] = c1;
              end
            endcase
          end
        end
      endcase
    end
  end

  // Load the result register from a held element when it is empty or being drained
  assign load = item_valid && (!m_axis_tvalid || m_axis_tready);
  assign take = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      idx           <= '0;
      next_id       <= '0;
    end else begin
      if (load) begin
        m_axis_tvalid <= 1'b1;
        idx           <= is_last ? '0 : idx + IDX_BITS'(1);
        if (!item.err) begin
          next_id <= next_id + ID_BITS'(1);
        end
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      id_q    <= next_id;
      shape_q <= shape_next;
      mat_q   <= mat_next;
      vert_q  <= vert_next;
      last_q  <= is_last;
    end
  end

  assign m_axis_tdata = {vert_q, mat_q, id_q};
  assign m_axis_tuser = shape_q;
  assign m_axis_tlast = last_q;

  `MLEC_ASSERT_IMP(a_err_last, m_axis_tvalid && (m_axis_tuser == SHAPE_ERROR), m_axis_tlast, "error result without tlast")
  `MLEC_ASSERT_IMP(a_idx_range, item_valid, idx < count, "result index past element count")
  `MLEC_ASSERT_IMP(a_err_single, item_valid && item.err, is_last, "error element emits more than one result")
  `MLEC_ASSERT_NXT(a_id_adv, load && !item.err, next_id == $past(next_id) + ID_BITS'(1), "element id did not advance")
  `MLEC_ASSERT_NXT(a_id_hold, load && item.err, $stable(next_id), "element id moved on error result")

endmodule

`default_nettype wire

/* rtl/core/mesh_layer_extrusion_connectivity.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel    Direction  Contents
// s_axis     in         one base element and its layer number
// m_axis     out        extruded elements, tlast on the final one per input
// apb        in/out     eight configuration registers at byte offsets 4*i
//
// Each input gives 1 to 5 results, one per cycle while m_axis accepts them;
// an input occupies the holding register until its last result is loaded,
// so the sustained input rate is set by the single result register.
// From input transfer to first result the data passes the holding register,
// then the result register.
// Reset is synchronous; it clears valids, the result index and the id counter.
// A stalled m_axis holds its result and backs up into s_axis.

module mesh_layer_extrusion_connectivity (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // material, corner_a, corner_b, corner_c, corner_d, layer
  input  wire logic [mlec_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,
  // elem_dim, elem_is_quad
  input  wire logic [mlec_pkg::S_TUSER_BITS-1:0]  s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // elem_id, elem_material, vertex_0 .. vertex_7
  output logic [mlec_pkg::M_TDATA_BITS-1:0]       m_axis_tdata,
  // shape
  output logic [mlec_pkg::M_TUSER_BITS-1:0]       m_axis_tuser,
  output logic                                    m_axis_tlast,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mlec_pkg::PADDR_BITS-1:0]    paddr,
  input  wire logic [mlec_pkg::PDATA_BITS-1:0]    pwdata,
  output logic      [mlec_pkg::PDATA_BITS-1:0]    prdata,
  output logic                                    pready
);
  import mlec_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  take;

  mlec_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mlec_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg           (cfg),
    .take          (take),
    .item_valid    (item_valid),
    .item          (item)
  );

  mlec_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .item_valid    (item_valid),
    .item          (item),
    .take          (take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* test/mesh_layer_extrusion_connectivity_tb.sv */
`timescale 1ns / 1ps

module mesh_layer_extrusion_connectivity_tb;
  import mlec_pkg::*;

  typedef struct packed {
    logic [1:0]  dim;
    logic        is_quad;
    logic [15:0] material;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic [15:0] d;
    logic [7:0]  layer;
  } base_elem_t;

  typedef struct packed {
    logic [23:0]      id;
    shape_t           shape;
    logic [15:0]      mat;
    logic [7:0][23:0] v;
    logic             last;
  } ext_elem_t;

  logic                     clk;
  logic                     rst;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  // material, corner_a, corner_b, corner_c, corner_d, layer
  logic [S_TDATA_BITS-1:0]  s_axis_tdata;
  // elem_dim, elem_is_quad
  logic [S_TUSER_BITS-1:0]  s_axis_tuser;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  // elem_id, elem_material, vertex_0 .. vertex_7
  logic [M_TDATA_BITS-1:0]  m_axis_tdata;
  // shape
  logic [M_TUSER_BITS-1:0]  m_axis_tuser;
  logic                     m_axis_tlast;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [PADDR_BITS-1:0]    paddr;
  logic [PDATA_BITS-1:0]    pwdata;
  logic [PDATA_BITS-1:0]    prdata;
  logic                     pready;

  // configuration as the block should hold it
  logic [1:0]  cfg_mesh_dim;
  logic [7:0]  cfg_layer_count;
  logic [16:0] cfg_node_count;
  logic        cfg_use_quads;
  logic        cfg_use_prisms;
  logic        cfg_use_tetra;
  logic [15:0] cfg_front_mat;
  logic [15:0] cfg_back_mat;
  logic [23:0] id_counter;

  ext_elem_t pending_elems[$];
  ext_elem_t want_elem;
  int        mismatch_count;
  int        burst_left;
  int        tx_gap_max;
  int        rx_mode;
  int        rx_phase;
  int        hold_cycles;
  logic      hold_off_req;

  mesh_layer_extrusion_connectivity uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    end
  endtask

  function automatic logic [23:0] node_at(input logic [15:0] p, input logic [23:0] off);
    node_at = {8'd0, p} + off;
  endfunction

  function automatic void push_elem(input shape_t sh, input logic [15:0] mat,
                                    input logic [7:0][23:0] v);
    ext_elem_t e;
    e.id = id_counter;
    e.shape = sh;
    e.mat = mat;
    e.v = v;
    e.last = 1'b0;
    pending_elems.push_back(e);
    id_counter = id_counter + 24'd1;
  endfunction

  // Work out every element one base element extrudes to, in emission order.
  function automatic void predict_extrusion(input base_elem_t e);
    logic [31:0]      lo_prod;
    logic [31:0]      hi_prod;
    logic [23:0]      a0, b0, c0, d0, a1, b1, c1, d1;
    logic             first_l, last_l, bnd;
    logic [7:0][23:0] v;
    ext_elem_t        tail;
    shape_t           face;
    if (e.dim == DIM_BAD || e.layer == 8'd0 || e.layer > cfg_layer_count) begin
      tail.id = id_counter;
      tail.shape = SHAPE_ERROR;
      tail.mat = e.material;
      tail.v = '0;
      tail.last = 1'b1;
      pending_elems.push_back(tail);
      return;
    end
    lo_prod = (32'(e.layer) - 32'd1) * 32'(cfg_node_count);
    hi_prod = 32'(e.layer) * 32'(cfg_node_count);
    a0 = node_at(e.a, lo_prod[23:0]);
    b0 = node_at(e.b, lo_prod[23:0]);
    c0 = node_at(e.c, lo_prod[23:0]);
    d0 = node_at(e.d, lo_prod[23:0]);
    a1 = node_at(e.a, hi_prod[23:0]);
    b1 = node_at(e.b, hi_prod[23:0]);
    c1 = node_at(e.c, hi_prod[23:0]);
    d1 = node_at(e.d, hi_prod[23:0]);
    first_l = (e.layer == 8'd1);
    last_l = (e.layer == cfg_layer_count);
    bnd = (cfg_mesh_dim == e.dim);
    if (e.dim == DIM_POINT) begin
      if (bnd && first_l) begin
        v = '0; v[0] = a0;
        push_elem(SHAPE_POINT, cfg_front_mat, v);
      end
      if (bnd && last_l) begin
        v = '0; v[0] = a1;
        push_elem(SHAPE_POINT, cfg_back_mat, v);
      end
      v = '0; v[0] = a0; v[1] = a1;
      push_elem(SHAPE_LINE, e.material, v);
    end else if (e.dim == DIM_LINE) begin
      if (bnd && first_l) begin
        v = '0; v[0] = a0; v[1] = b0;
        push_elem(SHAPE_LINE, cfg_front_mat, v);
      end
      if (bnd && last_l) begin
        v = '0; v[0] = a1; v[1] = b1;
        push_elem(SHAPE_LINE, cfg_back_mat, v);
      end
      if (cfg_use_quads) begin
        v = '0; v[0] = a0; v[1] = b0; v[2] = b1; v[3] = a1;
        push_elem(SHAPE_QUAD, e.material, v);
      end else begin
        v = '0; v[0] = a0; v[1] = b0; v[2] = a1;
        push_elem(SHAPE_TRI, e.material, v);
        v = '0; v[0] = b0; v[1] = b1; v[2] = a1;
        push_elem(SHAPE_TRI, e.material, v);
      end
    end else begin
      face = e.is_quad ? SHAPE_QUAD : SHAPE_TRI;
      if (bnd && first_l) begin
        v = '0; v[0] = a0; v[1] = b0; v[2] = c0;
        if (e.is_quad) v[3] = d0;
        push_elem(face, cfg_front_mat, v);
      end
      if (bnd && last_l) begin
        v = '0; v[0] = a1; v[1] = b1; v[2] = c1;
        if (e.is_quad) v[3] = d1;
        push_elem(face, cfg_back_mat, v);
      end
      if (cfg_use_prisms) begin
        v = '0; v[0] = a0; v[1] = b0; v[2] = c0; v[3] = a1; v[4] = b1; v[5] = c1;
        push_elem(SHAPE_PRISM, e.material, v);
      end else if (!cfg_use_tetra) begin
        v[0] = a0; v[1] = b0; v[2] = c0; v[3] = d0;
        v[4] = a1; v[5] = b1; v[6] = c1; v[7] = d1;
        push_elem(SHAPE_CUBE, e.material, v);
      end else begin
        v = '0; v[0] = a0; v[1] = b0; v[2] = a1; v[3] = c0;
        push_elem(SHAPE_TETRA, e.material, v);
        v = '0; v[0] = b0; v[1] = b1; v[2] = a1; v[3] = c0;
        push_elem(SHAPE_TETRA, e.material, v);
        v = '0; v[0] = a1; v[1] = b1; v[2] = c1; v[3] = c0;
        push_elem(SHAPE_TETRA, e.material, v);
      end
    end
    // flag the final element of this input
    tail = pending_elems.pop_back();
    tail.last = 1'b1;
    pending_elems.push_back(tail);
  endfunction

  function automatic base_elem_t mk_elem(input logic [1:0] dim, input logic is_quad,
                                         input logic [15:0] mat, input logic [15:0] a,
                                         input logic [15:0] b, input logic [15:0] c,
                                         input logic [15:0] d, input logic [7:0] layer);
    base_elem_t e;
    e.dim = dim;
    e.is_quad = is_quad;
    e.material = mat;
    e.a = a;
    e.b = b;
    e.c = c;
    e.d = d;
    e.layer = layer;
    return e;
  endfunction

  // Called right after a rising edge; returns right after the transfer edge
  // or after the idle gap that follows it.
  task automatic send_elem(input base_elem_t e);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {e.layer, e.d, e.c, e.b, e.a, e.material};
    s_axis_tuser <= {e.is_quad, e.dim};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_extrusion(e);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_for_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input reg_index_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_MESH_DIM:        cfg_mesh_dim = val[1:0];
      REG_LAYER_COUNT:     cfg_layer_count = val[7:0];
      REG_BASE_NODE_COUNT: cfg_node_count = val[16:0];
      REG_USE_QUADS:       cfg_use_quads = val[0];
      REG_USE_PRISMS:      cfg_use_prisms = val[0];
      REG_USE_TETRA:       cfg_use_tetra = val[0];
      REG_FRONT_MATERIAL:  cfg_front_mat = val[15:0];
      REG_BACK_MATERIAL:   cfg_back_mat = val[15:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apply_config(input logic [1:0] md, input logic [7:0] lc,
                              input logic [16:0] nc, input logic uq, input logic up,
                              input logic ut, input logic [15:0] fm, input logic [15:0] bm);
    apb_write(REG_MESH_DIM, 32'(md));
    apb_write(REG_LAYER_COUNT, 32'(lc));
    apb_write(REG_BASE_NODE_COUNT, 32'(nc));
    apb_write(REG_USE_QUADS, 32'(uq));
    apb_write(REG_USE_PRISMS, 32'(up));
    apb_write(REG_USE_TETRA, 32'(ut));
    apb_write(REG_FRONT_MATERIAL, {16'd0, fm});
    apb_write(REG_BACK_MATERIAL, {16'd0, bm});
  endtask

  function automatic base_elem_t random_elem();
    base_elem_t e;
    int pick;
    e.dim = 2'($urandom_range(0, 2));
    e.is_quad = 1'($urandom_range(0, 1));
    e.material = 16'($urandom);
    e.a = 16'($urandom_range(0, 65535));
    e.b = 16'($urandom_range(0, 65535));
    e.c = 16'($urandom_range(0, 65535));
    e.d = 16'($urandom_range(0, 65535));
    pick = $urandom_range(0, 3);
    if (pick == 0) e.layer = 8'd1;
    else if (pick == 1) e.layer = cfg_layer_count;
    else e.layer = 8'($urandom_range(1, cfg_layer_count));
    // a small share of malformed inputs
    pick = $urandom_range(0, 99);
    if (pick < 3) e.dim = DIM_BAD;
    else if (pick < 5) e.layer = 8'd0;
    else if (pick < 8 && cfg_layer_count != 8'd255) begin
      e.layer = 8'($urandom_range(cfg_layer_count + 1, 255));
    end
    return e;
  endfunction

  task automatic test_default_config();
    rx_mode = 1;
    tx_gap_max = 3;
    send_elem(mk_elem(DIM_SURF, 1'b0, 16'd7, 16'd1, 16'd2, 16'd3, 16'd4, 8'd1));
    send_elem(mk_elem(DIM_SURF, 1'b1, 16'd8, 16'd10, 16'd11, 16'd12, 16'd13, 8'd1));
    send_elem(mk_elem(DIM_POINT, 1'b0, 16'd9, 16'd5, 16'd0, 16'd0, 16'd0, 8'd1));
    send_elem(mk_elem(DIM_LINE, 1'b0, 16'hFFFF, 16'd20, 16'd21, 16'd0, 16'd0, 8'd1));
    wait_for_idle();
  endtask

  task automatic test_point_line_extrusion();
    apply_config(2'd0, 8'd3, 17'd100, 1'b1, 1'b0, 1'b0, 16'd11, 16'd22);
    rx_mode = 2;
    send_elem(mk_elem(DIM_POINT, 1'b0, 16'd1, 16'd40, 16'd0, 16'd0, 16'd0, 8'd1));
    send_elem(mk_elem(DIM_POINT, 1'b1, 16'd2, 16'd41, 16'd0, 16'd0, 16'd0, 8'd2));
    send_elem(mk_elem(DIM_POINT, 1'b0, 16'd3, 16'd42, 16'd0, 16'd0, 16'd0, 8'd3));
    wait_for_idle();
    apb_write(REG_MESH_DIM, 32'(DIM_LINE));
    send_elem(mk_elem(DIM_LINE, 1'b0, 16'd4, 16'd1, 16'd2, 16'd0, 16'd0, 8'd1));
    send_elem(mk_elem(DIM_LINE, 1'b0, 16'd5, 16'd3, 16'd4, 16'd0, 16'd0, 8'd3));
    wait_for_idle();
    apb_write(REG_USE_QUADS, 32'd0);
    send_elem(mk_elem(DIM_LINE, 1'b0, 16'd6, 16'd5, 16'd6, 16'd0, 16'd0, 8'd2));
    wait_for_idle();
  endtask

  task automatic test_surface_extrusion();
    apply_config(2'd2, 8'd3, 17'd1000, 1'b1, 1'b1, 1'b1, 16'd33, 16'd44);
    rx_mode = 0;
    tx_gap_max = 0;
    send_elem(mk_elem(DIM_SURF, 1'b0, 16'd1, 16'd1, 16'd2, 16'd3, 16'd4, 8'd1));
    send_elem(mk_elem(DIM_SURF, 1'b1, 16'd2, 16'd5, 16'd6, 16'd7, 16'd8, 8'd3));
    wait_for_idle();
    apb_write(REG_USE_PRISMS, 32'd0);
    send_elem(mk_elem(DIM_SURF, 1'b0, 16'd3, 16'd9, 16'd10, 16'd11, 16'd12, 8'd2));
    send_elem(mk_elem(DIM_SURF, 1'b1, 16'd4, 16'd13, 16'd14, 16'd15, 16'd16, 8'd1));
    wait_for_idle();
    // mesh dimension that no element has: never a boundary copy
    apply_config(2'd3, 8'd1, 17'd1000, 1'b1, 1'b0, 1'b0, 16'd33, 16'd44);
    send_elem(mk_elem(DIM_SURF, 1'b0, 16'd5, 16'd17, 16'd18, 16'd19, 16'd20, 8'd1));
    wait_for_idle();
  endtask

  task automatic test_bad_inputs();
    apply_config(2'd2, 8'd3, 17'd7, 1'b1, 1'b0, 1'b0, 16'd1, 16'd2);
    tx_gap_max = 2;
    rx_mode = 1;
    send_elem(mk_elem(DIM_BAD, 1'b1, 16'h1234, 16'd1, 16'd2, 16'd3, 16'd4, 8'd1));
    send_elem(mk_elem(DIM_SURF, 1'b0, 16'h4321, 16'd1, 16'd2, 16'd3, 16'd4, 8'd0));
    send_elem(mk_elem(DIM_LINE, 1'b0, 16'h5555, 16'd1, 16'd2, 16'd3, 16'd4, 8'd4));
    wait_for_idle();
  endtask

  task automatic test_id_extremes();
    apply_config(2'd2, 8'd255, 17'd65536, 1'b0, 1'b0, 1'b0, 16'h8000, 16'h7FFF);
    send_elem(mk_elem(DIM_SURF, 1'b1, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 8'd255));
    send_elem(mk_elem(DIM_SURF, 1'b0, 16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0, 8'd1));
    send_elem(mk_elem(DIM_POINT, 1'b0, 16'h0000, 16'hFFFF, 16'd0, 16'd0, 16'd0, 8'd255));
    wait_for_idle();
  endtask

  task automatic test_stalled_output();
    apply_config(2'd2, 8'd2, 17'd300, 1'b0, 1'b0, 1'b1, 16'd5, 16'd6);
    tx_gap_max = 0;
    hold_cycles = 200;
    hold_off_req = 1'b1;
    repeat (16) send_elem(random_elem());
    wait_for_idle();
  endtask

  task automatic test_random_phases();
    logic [7:0]  lc;
    logic [16:0] nc;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin lc = 8'd1; nc = 17'd1; end
        1: begin lc = 8'd255; nc = 17'd65536; end
        2: begin lc = 8'($urandom_range(1, 8)); nc = 17'($urandom_range(1, 500)); end
        default: begin
          lc = 8'($urandom_range(1, 255));
          nc = 17'($urandom_range(1, 65536));
        end
      endcase
      apply_config(2'($urandom_range(0, 3)), lc, nc, 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   16'($urandom), 16'($urandom));
      rx_mode = ph % 3;
      tx_gap_max = (ph == 3) ? 0 : $urandom_range(1, 8);
      repeat (80) send_elem(random_elem());
      wait_for_idle();
    end
  endtask

  // output side: check each transfer against the oldest expected element
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_elems.size() == 0) begin
        report_mismatch("unexpected transfer, elem_id", 32'(m_axis_tdata[23:0]), 32'd0);
      end else begin
        want_elem = pending_elems.pop_front();
        if (m_axis_tdata[23:0] !== want_elem.id)
          report_mismatch("elem_id", 32'(m_axis_tdata[23:0]), 32'(want_elem.id));
        if (m_axis_tuser !== want_elem.shape)
          report_mismatch("shape", 32'(m_axis_tuser), 32'(want_elem.shape));
        if (m_axis_tdata[39:24] !== want_elem.mat)
          report_mismatch("elem_material", 32'(m_axis_tdata[39:24]), 32'(want_elem.mat));
        for (int i = 0; i < 8; i++) begin
          if (m_axis_tdata[40 + 24 * i +: 24] !== want_elem.v[i])
            report_mismatch($sformatf("vertex_%0d", i),
                            32'(m_axis_tdata[40 + 24 * i +: 24]), 32'(want_elem.v[i]));
        end
        if (m_axis_tlast !== want_elem.last)
          report_mismatch("last", 32'(m_axis_tlast), 32'(want_elem.last));
      end
    end
  end

  // output side backpressure
  initial begin
    m_axis_tready <= 1'b0;
    rx_phase = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          default: begin
            rx_phase = (rx_phase + 1) % 7;
            m_axis_tready <= (rx_phase >= 3);
          end
        endcase
      end
    end
  end

  initial begin
    #8_000_000;
    $display("FAIL mesh_layer_extrusion_connectivity");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    hold_off_req = 1'b0;
    hold_cycles = 0;
    rx_mode = 0;
    tx_gap_max = 0;
    burst_left = 1;
    mismatch_count = 0;
    cfg_mesh_dim = DIM_SURF;
    cfg_layer_count = 8'd1;
    cfg_node_count = 17'd1;
    cfg_use_quads = 1'b1;
    cfg_use_prisms = 1'b0;
    cfg_use_tetra = 1'b0;
    cfg_front_mat = FRONT_MATERIAL_RST;
    cfg_back_mat = BACK_MATERIAL_RST;
    id_counter = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_config();
    test_point_line_extrusion();
    test_surface_extrusion();
    test_bad_inputs();
    test_id_extremes();
    test_stalled_output();
    test_random_phases();

    wait_for_idle();
    repeat (20) @(posedge clk);
    if (pending_elems.size() != 0)
      report_mismatch("elements never produced", 32'(pending_elems.size()), 32'd0);
    if (mismatch_count == 0) begin
      $display("PASS mesh_layer_extrusion_connectivity");
    end else begin
      $display("FAIL mesh_layer_extrusion_connectivity");
    end
    $finish;
  end

endmodule
